// ----- sv/direct_mapped_cache_tag_store_defines.svh -----
// Assertion macros for the direct-mapped cache tag store checker.
`ifndef DIRECT_MAPPED_CACHE_TAG_STORE_DEFINES_SVH
`define DIRECT_MAPPED_CACHE_TAG_STORE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst is high.
`define DMC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, off while rst is high.
`define DMC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- sv/dmc_pkg.sv -----
// Shared types, constants and helpers for the direct-mapped cache tag store.
`default_nettype none
package dmc_pkg;

  localparam int MAX_SETS     = 1024;  // power of two
  localparam int ADDR_WIDTH   = 48;
  localparam int IDX_W        = $clog2(MAX_SETS);
  localparam int TAG_W        = ADDR_WIDTH;
  localparam int CNT_W        = 48;
  localparam int OFF_W        = 5;
  localparam int SETB_W       = 4;
  localparam int SHIFT_W      = 6;
  localparam int CFG_IDX_W    = 1;
  localparam int CFG_DATA_W   = 5;

  localparam logic [OFF_W-1:0]  OFFSET_BITS_RST = OFF_W'(6);
  localparam logic [SETB_W-1:0] SET_BITS_RST    = SETB_W'(7);
  localparam logic [SETB_W-1:0] SET_BITS_MAX    = SETB_W'(IDX_W);

  typedef enum logic [1:0] {
    KIND_READ  = 2'd0,
    KIND_WRITE = 2'd1,
    KIND_FLUSH = 2'd2,
    KIND_STATS = 2'd3
  } kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_OFFSET_BITS = 1'b0,
    CFG_SET_BITS    = 1'b1
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_LOOKUP,
    ST_FLUSH,
    ST_UPDATE
  } state_t;

  // Controller to datapath.
  typedef struct packed {
    logic load_in;  // capture the accepted word
    logic lookup;   // split address, read the tag entry
    logic clear;    // clear one entry, step the sweep counter
    logic update;   // compare, fill, count, load the result
  } dmc_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic clear_last;  // sweep counter on the last entry
    logic out_full;    // result register holds a word not yet taken
  } dmc_status_t;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    sat_inc = (v == {CNT_W{1'b1}}) ? v : v + CNT_W'(1);
  endfunction

endpackage
`default_nettype wire

// ----- sv/dmc_ctrl.sv -----
// Controller state machine for the direct-mapped cache tag store.
`default_nettype none
module dmc_ctrl
  import dmc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  input  wire logic [1:0]  kind,
  input  wire dmc_status_t status,
  output dmc_cmd_t         cmd,
  output logic             in_stall
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_INIT;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_stall   = 1'b1;
    case (state)
      ST_INIT: begin
        cmd.clear = 1'b1;
        if (status.clear_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_stall    = 1'b0;
        cmd.load_in = in_valid;
        if (in_valid) begin
          state_next = (kind == KIND_FLUSH) ? ST_FLUSH : ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        cmd.lookup = 1'b1;
        state_next = ST_UPDATE;
      end
      ST_FLUSH: begin
        cmd.clear = 1'b1;
        if (status.clear_last) begin
          state_next = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        // hold until the result register is free
        if (!status.out_full) begin
          cmd.update = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_INIT;
      end
    endcase
  end

endmodule
`default_nettype wire

// ----- sv/dmc_datapath.sv -----
// Datapath: config registers, address split, tag memory, counters, result register.
`default_nettype none
module dmc_datapath
  import dmc_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire dmc_cmd_t              cmd,
  output dmc_status_t                status,
  input  wire logic [1:0]            kind,
  input  wire logic [ADDR_WIDTH-1:0] address,
  input  wire logic                  cfg_write,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  input  wire logic                  out_stall,
  output logic                       out_valid,
  output logic                       hit,
  output logic [CNT_W-1:0]           reads,
  output logic [CNT_W-1:0]           read_misses,
  output logic [CNT_W-1:0]           writes,
  output logic [CNT_W-1:0]           write_misses
);

  logic [OFF_W-1:0]      offset_bits;
  logic [SETB_W-1:0]     set_bits;
  logic [1:0]            kind_reg;
  logic [ADDR_WIDTH-1:0] addr_reg;
  logic [IDX_W-1:0]      idx_reg;
  logic [TAG_W-1:0]      tag_reg;
  logic [IDX_W-1:0]      clr_cnt;
  logic [TAG_W:0]        rd_data;  // {valid, tag}
  logic [TAG_W:0]        tag_mem [MAX_SETS];

  logic [SETB_W-1:0]     eff_sb;
  logic [SHIFT_W-1:0]    tag_sh;
  logic [ADDR_WIDTH-1:0] addr_off;
  logic [IDX_W-1:0]      idx_mask;
  logic [IDX_W-1:0]      idx_calc;
  logic [TAG_W-1:0]      tag_calc;
  logic                  is_access;
  logic                  lookup_hit;
  logic                  mem_we;
  logic [IDX_W-1:0]      mem_waddr;
  logic [TAG_W:0]        mem_wdata;

  // Config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      offset_bits <= OFFSET_BITS_RST;
      set_bits    <= SET_BITS_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_OFFSET_BITS: offset_bits <= cfg_data[OFF_W-1:0];
        CFG_SET_BITS:    set_bits    <= cfg_data[SETB_W-1:0];
        default:         ;
      endcase
    end
  end

  // Address split
  always_comb begin
    eff_sb   = (set_bits > SET_BITS_MAX) ? SET_BITS_MAX : set_bits;
    tag_sh   = SHIFT_W'(offset_bits) + SHIFT_W'(eff_sb);
    addr_off = addr_reg >> offset_bits;
    idx_mask = ~({IDX_W{1'b1}} << eff_sb);
    idx_calc = addr_off[IDX_W-1:0] & idx_mask;
    tag_calc = TAG_W'(addr_reg >> tag_sh);
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      kind_reg <= kind;
      addr_reg <= address;
    end
    if (cmd.lookup) begin
      idx_reg <= idx_calc;
      tag_reg <= tag_calc;
    end
  end

  // Sweep counter wraps to zero after the last entry
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (cmd.clear) begin
      clr_cnt <= clr_cnt + IDX_W'(1);
    end
  end

  assign is_access  = (kind_reg == KIND_READ) || (kind_reg == KIND_WRITE);
  assign lookup_hit = is_access && rd_data[TAG_W] && (rd_data[TAG_W-1:0] == tag_reg);

  always_comb begin
    mem_we    = cmd.clear || (cmd.update && is_access && !lookup_hit);
    mem_waddr = cmd.clear ? clr_cnt : idx_reg;
    mem_wdata = cmd.clear ? '0 : {1'b1, tag_reg};
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      tag_mem[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.lookup) begin
      rd_data <= tag_mem[idx_calc];
    end
  end

  // Counters double as the result payload; they move only when the result loads, or under reset
  always_ff @(posedge clk) begin
    if (rst) begin
      reads        <= '0;
      read_misses  <= '0;
      writes       <= '0;
      write_misses <= '0;
    end else if (cmd.update) begin
      case (kind_reg)
        KIND_READ: begin
          reads <= sat_inc(reads);
          if (!lookup_hit) read_misses <= sat_inc(read_misses);
        end
        KIND_WRITE: begin
          writes <= sat_inc(writes);
          if (!lookup_hit) write_misses <= sat_inc(write_misses);
        end
        KIND_STATS: begin
          reads        <= '0;
          read_misses  <= '0;
          writes       <= '0;
          write_misses <= '0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.update) begin
      hit <= lookup_hit;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= cmd.update || (out_valid && out_stall);
    end
  end

  assign status.clear_last = &clr_cnt;
  assign status.out_full   = out_valid && out_stall;

endmodule
`default_nettype wire

// ----- sv/direct_mapped_cache_tag_store.sv -----
// Top level of the direct-mapped cache tag store: controller plus datapath.
// Access or statistics reset: the word is taken in idle, passes the lookup state, and the result loads in update.
// Flush: the sweep clears every tag entry, one entry cleared a cycle, then the update state loads the result.
// A new word is taken only in idle, once the read-compare-fill walk of the last word has left the update state.
// Reset: counters zero, offset_bits 6, set_bits 7, then a sweep clears every
// tag entry; in_stall stays high during the sweep. Config writes are taken whenever rst is low.
`default_nettype none
module direct_mapped_cache_tag_store
  import dmc_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  // input channel
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic [1:0]            kind,
  input  wire logic [ADDR_WIDTH-1:0] address,
  // result channel
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic                       hit,
  output logic [CNT_W-1:0]           reads,
  output logic [CNT_W-1:0]           read_misses,
  output logic [CNT_W-1:0]           writes,
  output logic [CNT_W-1:0]           write_misses,
  // config write port
  input  wire logic                  cfg_write,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  dmc_cmd_t    cmd;
  dmc_status_t status;

  // Sequence each word: idle -> lookup -> update, or idle -> flush sweep -> update.
  // The update step waits for the result register, so a finished word can sit
  // on the output while the block goes back to idle and takes the next word.
  dmc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .kind     (kind),
    .status   (status),
    .cmd      (cmd),
    .in_stall (in_stall)
  );

  // Hold config, split the address, keep the tag memory (valid bit stored with
  // each tag), count accesses and misses, and drive the result word.
  dmc_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .kind         (kind),
    .address      (address),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .out_stall    (out_stall),
    .out_valid    (out_valid),
    .hit          (hit),
    .reads        (reads),
    .read_misses  (read_misses),
    .writes       (writes),
    .write_misses (write_misses)
  );

endmodule
`default_nettype wire

// ----- sv/dmc_checker.sv -----
// Port-level checker for the direct-mapped cache tag store, bound to the top level.
`default_nettype none
`include "direct_mapped_cache_tag_store_defines.svh"
module dmc_checker
  import dmc_pkg::*;
(
  input wire logic                  clk,
  input wire logic                  rst,
  input wire logic                  out_valid,
  input wire logic                  out_stall,
  input wire logic                  hit,
  input wire logic [CNT_W-1:0]      reads,
  input wire logic [CNT_W-1:0]      read_misses,
  input wire logic [CNT_W-1:0]      writes,
  input wire logic [CNT_W-1:0]      write_misses
);

  `DMC_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid, "result word dropped while stalled")
  `DMC_ASSERT_NEXT(a_out_stable, out_valid && out_stall, $stable(reads) && $stable(writes) && $stable(hit), "stalled result word changed")
  `DMC_ASSERT_NOW(a_read_miss_le, out_valid, read_misses <= reads, "read misses exceed reads")
  `DMC_ASSERT_NOW(a_write_miss_le, out_valid, write_misses <= writes, "write misses exceed writes")

endmodule

bind direct_mapped_cache_tag_store dmc_checker u_dmc_checker (.*);
`default_nettype wire
